@@ rtl/mvsm_pkg.sv @@
package mvsm_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_START = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0,
    KIND_START = 2'd1,
    KIND_FULL  = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    CFG_MASTER   = 3'd0,
    CFG_MUTE     = 3'd1,
    CFG_PASS     = 3'd2,
    CFG_AMBIENCE = 3'd3,
    CFG_MUSIC    = 3'd4,
    CFG_EFFECTS  = 3'd5,
    CFG_SPEECH   = 3'd6,
    CFG_UNUSED   = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_VREAD,
    ST_VWAIT,
    ST_GAIN1,
    ST_GAIN2,
    ST_SREAD,
    ST_SWAIT,
    ST_ACC,
    ST_OUT
  } state_t;

  localparam int unsigned UNITY_GAIN   = 32768;
  localparam int unsigned FRAC_SHIFT   = 45;
  localparam int unsigned SAMPLE_WORDS = 65536;

  // voice table entry
  typedef struct packed {
    logic [15:0] base;
    logic [15:0] length;
    logic [15:0] position;
    logic        stereo;
    logic [2:0]  category;
    logic [15:0] gain;
  } voice_t;

  function automatic logic signed [15:0] sat16(input logic signed [37:0] v);
    if (v > 38'sd32767) begin
      return 16'sh7fff;
    end else if (v < -38'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

@@ rtl/mvsm_sample_ram.sv @@
module mvsm_sample_ram
  import mvsm_pkg::*;
#(
  parameter int AW = 16
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic signed [15:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic signed [15:0] rdata
);

  logic signed [15:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/mvsm_voice_ram.sv @@
module mvsm_voice_ram
  import mvsm_pkg::*;
#(
  parameter int VW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [VW-1:0] waddr,
  input  voice_t        wdata,
  input  logic [VW-1:0] raddr,
  output voice_t        rdata
);

  voice_t mem [2**VW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/multi_voice_stereo_mixer.sv @@
// Multi-voice stereo mixer. Load items (mode 0) write one Q1.15 word into the
// sample store. Start items (mode 1) claim the lowest free voice slot and
// return kind 1, or kind 2 if all slots are busy; the free slot search steps
// one slot per cycle. Tick items (mode 2) return one saturated stereo frame
// (kind 0), seeded with the mic sample when pass_through is set and the mic is
// present. The tick walks the slots one by one through the voice table memory;
// an active mono voice takes a table read, two gain multiplies, a sample store
// read, and an accumulate and write back, an active stereo voice a second store
// read and accumulate, and a voice that has run out a table read, after which
// its slot is freed. The gain product M*C*V is formed over two registered
// multiplies; the sample multiply is combinational and feeds the accumulate.
// One item is in flight at a time; the result waits in an output register, and
// the next item is accepted as soon as that register is handed off. The sample
// store has no reset; reading a word never loaded returns undefined data.
// Configuration must be written only while idle; the block does not enforce it.
module multi_voice_stereo_mixer
  import mvsm_pkg::*;
#(
  parameter int NUM_VOICES   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic [15:0]        in_load_address,
  input  logic signed [15:0] in_load_value,
  input  logic [15:0]        in_clip_base,
  input  logic [15:0]        in_clip_frames,
  input  logic               in_clip_stereo,
  input  logic [2:0]         in_clip_category,
  input  logic [15:0]        in_clip_gain,
  input  logic signed [15:0] in_mic_sample,
  input  logic               in_mic_present,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic signed [15:0] out_left_out,
  output logic signed [15:0] out_right_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int AW = $clog2(SAMPLE_WORDS);
  localparam int CW = $clog2(NUM_VOICES + 1);

  // configuration registers
  logic [15:0] master_r, amb_r, mus_r, eff_r, spc_r;
  logic        mute_r, pass_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_r <= 16'(UNITY_GAIN);
      amb_r    <= 16'(UNITY_GAIN);
      mus_r    <= 16'(UNITY_GAIN);
      eff_r    <= 16'(UNITY_GAIN);
      spc_r    <= 16'(UNITY_GAIN);
      mute_r   <= 1'b0;
      pass_r   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MASTER:   master_r <= cfg_data;
        CFG_MUTE:     mute_r   <= cfg_data[0];
        CFG_PASS:     pass_r   <= cfg_data[0];
        CFG_AMBIENCE: amb_r    <= cfg_data;
        CFG_MUSIC:    mus_r    <= cfg_data;
        CFG_EFFECTS:  eff_r    <= cfg_data;
        CFG_SPEECH:   spc_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // control state
  state_t                 state_r, state_nxt;
  logic [NUM_VOICES-1:0]  active_r, active_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;   // walks 0..NUM_VOICES
  logic                   is_tick_r, is_tick_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             kind_r, kind_nxt;
  logic signed [15:0]     left_o_r, left_o_nxt, right_o_r, right_o_nxt;

  // payload registers
  voice_t                 start_r, start_nxt;
  logic signed [37:0]     acc_l_r, acc_l_nxt, acc_r_r, acc_r_nxt;
  logic [31:0]            g1_r, g1_nxt;
  logic [47:0]            g_r, g_nxt;
  logic                   half_r, half_nxt;   // 0 left word, 1 right word
  logic signed [15:0]     sl_r, sl_nxt;
  voice_t                 v_r, v_nxt;

  // memories
  logic                   s_we;
  logic [AW-1:0]          s_raddr;
  logic signed [15:0]     s_rdata;
  logic                   v_we;
  logic [VW-1:0]          v_waddr;
  voice_t                 v_wdata, v_rdata;

  logic [VW-1:0]          idx_slot;
  assign idx_slot = idx_r[VW-1:0];

  mvsm_sample_ram #(.AW(AW)) u_sram (
    .clk   (clk),
    .we    (s_we),
    .waddr (in_load_address[AW-1:0]),
    .wdata (in_load_value),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  mvsm_voice_ram #(.VW(VW)) u_vram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (idx_slot),
    .rdata (v_rdata)
  );

  // accept only when idle and the output register is free or being taken
  logic out_free;
  logic in_acc;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !(state_r == ST_IDLE && out_free);
  assign in_acc   = in_valid && !in_stall;
  assign s_we     = in_acc && (mode_t'(in_mode) == MODE_LOAD);

  // gain terms
  logic [15:0] m_eff, cat_g;
  logic [16:0] pos_inc;
  logic [15:0] addr_l;
  logic signed [63:0] prod;
  logic signed [37:0] term;

  assign m_eff = mute_r ? 16'd0 : master_r;

  always_comb begin
    case (v_r.category)
      3'd0:    cat_g = amb_r;
      3'd1:    cat_g = mus_r;
      3'd2:    cat_g = eff_r;
      3'd3:    cat_g = spc_r;
      default: cat_g = m_eff;
    endcase
  end

  assign pos_inc = {1'b0, v_r.position} + 17'd1;
  assign addr_l  = v_r.base + (v_r.stereo ? {v_r.position[14:0], 1'b0} : v_r.position)
                   + {15'd0, half_r};
  assign prod    = 64'(sl_r) * $signed({16'd0, g_r});
  assign term    = 38'(prod >>> FRAC_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= '0;
      idx_r       <= '0;
      is_tick_r   <= 1'b0;
      out_valid_r <= 1'b0;
      kind_r      <= KIND_FRAME;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      idx_r       <= idx_nxt;
      is_tick_r   <= is_tick_nxt;
      out_valid_r <= out_valid_nxt;
      kind_r      <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r   <= start_nxt;
    acc_l_r   <= acc_l_nxt;
    acc_r_r   <= acc_r_nxt;
    g1_r      <= g1_nxt;
    g_r       <= g_nxt;
    half_r    <= half_nxt;
    sl_r      <= sl_nxt;
    v_r       <= v_nxt;
    left_o_r  <= left_o_nxt;
    right_o_r <= right_o_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    idx_nxt       = idx_r;
    is_tick_nxt   = is_tick_r;
    out_valid_nxt = out_valid_r && out_stall;
    kind_nxt      = kind_r;
    left_o_nxt    = left_o_r;
    right_o_nxt   = right_o_r;
    start_nxt     = start_r;
    acc_l_nxt     = acc_l_r;
    acc_r_nxt     = acc_r_r;
    g1_nxt        = g1_r;
    g_nxt         = g_r;
    half_nxt      = half_r;
    sl_nxt        = sl_r;
    v_nxt         = v_r;
    v_we          = 1'b0;
    v_waddr       = idx_slot;
    v_wdata       = v_r;
    s_raddr       = addr_l[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          idx_nxt = '0;
          start_nxt.base     = in_clip_base;
          start_nxt.length   = in_clip_frames;
          start_nxt.position = 16'd0;
          start_nxt.stereo   = in_clip_stereo;
          start_nxt.category = in_clip_category;
          start_nxt.gain     = in_clip_gain;
          if (pass_r && in_mic_present) begin
            acc_l_nxt = 38'(in_mic_sample);
          end else begin
            acc_l_nxt = '0;
          end
          acc_r_nxt = acc_l_nxt;
          case (mode_t'(in_mode))
            MODE_START: begin
              is_tick_nxt = 1'b0;
              state_nxt   = ST_FIND;
            end
            MODE_TICK: begin
              is_tick_nxt = 1'b1;
              state_nxt   = ST_FIND;
            end
            default: ;
          endcase
        end
      end
      // step to the next slot of interest
      ST_FIND: begin
        if (idx_r == CW'(NUM_VOICES)) begin
          if (is_tick_r) begin
            kind_nxt    = KIND_FRAME;
            left_o_nxt  = sat16(acc_l_r);
            right_o_nxt = sat16(acc_r_r);
          end else begin
            kind_nxt    = KIND_FULL;
            left_o_nxt  = '0;
            right_o_nxt = '0;
          end
          state_nxt = ST_OUT;
        end else if (!is_tick_r && !active_r[idx_slot]) begin
          v_we       = 1'b1;
          v_wdata    = start_r;
          active_nxt[idx_slot] = 1'b1;
          kind_nxt    = KIND_START;
          left_o_nxt  = '0;
          right_o_nxt = '0;
          state_nxt   = ST_OUT;
        end else if (is_tick_r && active_r[idx_slot]) begin
          state_nxt = ST_VREAD;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      ST_VREAD: state_nxt = ST_VWAIT;
      ST_VWAIT: begin
        v_nxt     = v_rdata;
        half_nxt  = 1'b0;
        state_nxt = ST_GAIN1;
      end
      ST_GAIN1: begin
        g1_nxt = m_eff * cat_g;
        if (v_r.position < v_r.length) begin
          state_nxt = ST_GAIN2;
        end else begin
          active_nxt[idx_slot] = 1'b0;
          idx_nxt   = idx_r + CW'(1);
          state_nxt = ST_FIND;
        end
      end
      ST_GAIN2: begin
        g_nxt     = g1_r * v_r.gain;
        state_nxt = ST_SREAD;
      end
      ST_SREAD: state_nxt = ST_SWAIT;
      ST_SWAIT: begin
        sl_nxt    = s_rdata;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (v_r.stereo && !half_r) begin
          acc_l_nxt = acc_l_r + term;
          half_nxt  = 1'b1;
          state_nxt = ST_SREAD;
        end else begin
          if (v_r.stereo) begin
            acc_r_nxt = acc_r_r + term;
          end else begin
            acc_l_nxt = acc_l_r + term;
            acc_r_nxt = acc_r_r + term;
          end
          v_we             = 1'b1;
          v_wdata          = v_r;
          v_wdata.position = pos_inc[15:0];
          if (pos_inc >= {1'b0, v_r.length}) begin
            active_nxt[idx_slot] = 1'b0;
          end
          idx_nxt   = idx_r + CW'(1);
          state_nxt = ST_FIND;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = kind_r;
  assign out_left_out  = left_o_r;
  assign out_right_out = right_o_r;

`ifndef ASSERT_OFF
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall) else $error("accepted while busy");
  a_start_claims: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIND && state_nxt == ST_OUT && kind_nxt == KIND_START)
    |=> ($countones(active_r) == $countones($past(active_r)) + 1))
    else $error("start did not claim one slot");
  a_full_all: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_FULL && $rose(out_valid_r)) |-> (&active_r))
    else $error("full reported with a free slot");
  a_tick_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (is_tick_r && state_r != ST_IDLE) |=>
    ((active_r & ~$past(active_r)) == '0)) else $error("tick set a voice");
`endif

endmodule
